>>> design/standing_wave_mode_pixel_colormap_macros.svh
// Assertion helpers for the colormap block.
// Each helper samples on the rising edge of clk; the first two stand down
// while arst_n is low, the last one also watches the cycles in reset.
`ifndef STANDING_WAVE_MODE_PIXEL_COLORMAP_MACROS_SVH
`define STANDING_WAVE_MODE_PIXEL_COLORMAP_MACROS_SVH

// Same-cycle implication.
`define SWM_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("swm assertion failed");

// Next-cycle implication.
`define SWM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("swm assertion failed");

// Next-cycle implication that stays armed through reset.
`define SWM_ASSERT_RESET(label, ante, cons) \
	label: assert property (@(posedge clk) (ante) |=> (cons)) \
		else $error("swm reset assertion failed");

`endif

>>> design/swm_pkg.sv
`default_nettype none
package swm_pkg;

	// Image geometry and cosine table resolution.
	localparam int IMG_WIDTH = 512;
	localparam int IMG_HEIGHT = 512;
	localparam int COS_TABLE_BITS = 10;

	// Field widths.
	localparam int MODE_W = 4;
	localparam int PIX_W = 9;
	localparam int COLOR_W = 8;

	// Configuration port.
	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W = MODE_W;
	localparam logic [CFG_INDEX_W-1:0] REG_MODE_X = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_MODE_Y = CFG_INDEX_W'(1);
	localparam logic [MODE_W-1:0] MODE_RESET = MODE_W'(2);

	// Phase: a full turn is 4*QSTEPS.
	localparam int QSTEPS = 1 << COS_TABLE_BITS;
	localparam int PH_W = COS_TABLE_BITS + 2;
	localparam int ADDR_W = COS_TABLE_BITS + 1;
	localparam int COS_W = 15;

	// Constant division by (size - 1) through a reciprocal.
	localparam int PROD_W = MODE_W + PIX_W;
	localparam int NUM_W = PROD_W + COS_TABLE_BITS + 1;
	localparam int RECIP_W = NUM_W + 1;
	localparam int DIV_W = 12;
	localparam int REM_W = DIV_W + 1;
	localparam int KEEP_W = (PH_W > REM_W) ? PH_W : REM_W;
	localparam int DIV_X = IMG_WIDTH - 1;
	localparam int DIV_Y = IMG_HEIGHT - 1;
	localparam logic [DIV_W-1:0] DIV_X_V = DIV_W'(DIV_X);
	localparam logic [DIV_W-1:0] DIV_Y_V = DIV_W'(DIV_Y);
	localparam logic [RECIP_W-1:0] RECIP_X = RECIP_W'((64'd1 << NUM_W) / DIV_X);
	localparam logic [RECIP_W-1:0] RECIP_Y = RECIP_W'((64'd1 << NUM_W) / DIV_Y);

	// Colormap arithmetic, Q1.15.
	localparam int FRAC_W = 15;
	localparam int Q_W = 16;
	localparam logic [Q_W-1:0] ONE_Q15 = Q_W'(32768);
	localparam logic [COS_W-1:0] NODE_LIMIT = COS_W'(3276);
	localparam int NODE_GAIN = 10;
	localparam logic [COLOR_W-1:0] CMAX = COLOR_W'(255);

	// Items in flight from input register to output register.
	localparam int PIPE_DEPTH = 7;
	localparam int FLIGHT_W = $clog2(PIPE_DEPTH + 2);

	// Quarter-wave table, cos(k*pi/(2Q)) in unsigned Q0.15 for k = 0..Q.
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	typedef logic [COS_W-1:0] cos_rom_t [0:QSTEPS];

	function automatic cos_rom_t cos_rom_init();
		cos_rom_t rom;
		longint unsigned theta;
		longint unsigned x2;
		longint unsigned term;
		longint acc;
		int k;
		for (k = 0; k <= QSTEPS; k++) begin
			theta = (longint'(k) * HALF_PI_Q30) >> COS_TABLE_BITS;
			x2 = (theta * theta) >> 30;
			term = 64'd1 << 30;
			acc = longint'(term);
			term = ((term * x2) >> 30) / 64'd2;   acc = acc - longint'(term);
			term = ((term * x2) >> 30) / 64'd12;  acc = acc + longint'(term);
			term = ((term * x2) >> 30) / 64'd30;  acc = acc - longint'(term);
			term = ((term * x2) >> 30) / 64'd56;  acc = acc + longint'(term);
			term = ((term * x2) >> 30) / 64'd90;  acc = acc - longint'(term);
			term = ((term * x2) >> 30) / 64'd132; acc = acc + longint'(term);
			term = ((term * x2) >> 30) / 64'd182; acc = acc - longint'(term);
			term = ((term * x2) >> 30) / 64'd240; acc = acc + longint'(term);
			term = ((term * x2) >> 30) / 64'd306; acc = acc - longint'(term);
			if (acc < 0)
				acc = 0;
			acc = (acc + 16384) >>> 15;
			if (acc > 32767)
				acc = 32767;
			rom[k] = COS_W'(acc);
		end
		return rom;
	endfunction

	localparam cos_rom_t COS_ROM = cos_rom_init();

	// Table addresses and sign flips leaving the phase stages.
	typedef struct packed {
		logic flip_x;
		logic [ADDR_W-1:0] addr_x;
		logic flip_y;
		logic [ADDR_W-1:0] addr_y;
	} phase_t;

	// Cosine magnitudes and sign flips entering the shading stages.
	typedef struct packed {
		logic flip_x;
		logic [COS_W-1:0] cos_x;
		logic flip_y;
		logic [COS_W-1:0] cos_y;
	} shade_in_t;

endpackage
`default_nettype wire

>>> design/swm_pix_if.sv
`default_nettype none
interface swm_pix_if;
	import swm_pkg::*;
	logic valid;
	logic ready;
	logic [PIX_W-1:0] x_pixel;
	logic [PIX_W-1:0] y_pixel;

	modport source (output valid, output x_pixel, output y_pixel, input ready);
	modport sink (input valid, input x_pixel, input y_pixel, output ready);
endinterface
`default_nettype wire

>>> design/swm_rgb_if.sv
`default_nettype none
interface swm_rgb_if;
	import swm_pkg::*;
	logic valid;
	logic ready;
	logic [COLOR_W-1:0] red;
	logic [COLOR_W-1:0] green;
	logic [COLOR_W-1:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);
endinterface
`default_nettype wire

>>> design/swm_cfg_if.sv
`default_nettype none
interface swm_cfg_if;
	import swm_pkg::*;
	logic valid;
	logic ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> design/swm_ram.sv
`default_nettype none
module swm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic re,
	input wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end
endmodule
`default_nettype wire

>>> design/swm_phase.sv
`default_nettype none
module swm_phase (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [swm_pkg::PIX_W-1:0] x_pixel,
	input wire logic [swm_pkg::PIX_W-1:0] y_pixel,
	input wire logic [swm_pkg::MODE_W-1:0] mode_x,
	input wire logic [swm_pkg::MODE_W-1:0] mode_y,
	output logic out_valid,
	input wire logic out_ready,
	output swm_pkg::phase_t out_data
);
	import swm_pkg::*;

	localparam int MUL_W = PROD_W + RECIP_W;
	localparam int BACK_W = KEEP_W + DIV_W;

	logic v_s1, v_s2, v_s3;
	logic en_s1, en_s2, en_s3;
	logic [PROD_W-1:0] ax_s1, ay_s1, ax_s2, ay_s2;
	logic [KEEP_W-1:0] qx_s2, qy_s2;
	logic [PH_W-1:0] phx_s3, phy_s3;
	logic [MUL_W-1:0] mul_x, mul_y;

	// Quotient estimate is low by at most one; fix it with the remainder.
	function automatic logic [PH_W-1:0] fix_phase(
		input logic [PROD_W-1:0] a,
		input logic [KEEP_W-1:0] q0,
		input logic [DIV_W-1:0] div
	);
		logic [NUM_W-1:0] num;
		logic [BACK_W-1:0] back;
		logic [REM_W-1:0] rem;
		logic [KEEP_W-1:0] q;
		num = NUM_W'(a) << (COS_TABLE_BITS + 1);
		back = BACK_W'(q0) * BACK_W'(div);
		rem = num[REM_W-1:0] - back[REM_W-1:0];
		q = (rem >= REM_W'(div)) ? q0 + 1'b1 : q0;
		return q[PH_W-1:0];
	endfunction

	// Odd quadrants read the table mirrored; quadrants one and two negate.
	function automatic logic [ADDR_W:0] map_quad(input logic [PH_W-1:0] ph);
		logic [1:0] quad;
		logic [ADDR_W-1:0] r;
		quad = ph[PH_W-1:COS_TABLE_BITS];
		r = ADDR_W'(ph[COS_TABLE_BITS-1:0]);
		return {quad[1] ^ quad[0], quad[0] ? ADDR_W'(QSTEPS) - r : r};
	endfunction

	assign en_s3 = !v_s3 || out_ready;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign in_ready = en_s1;
	assign out_valid = v_s3;

	assign mul_x = MUL_W'(ax_s1) * MUL_W'(RECIP_X);
	assign mul_y = MUL_W'(ay_s1) * MUL_W'(RECIP_Y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1)
				v_s1 <= in_valid;
			if (en_s2)
				v_s2 <= v_s1;
			if (en_s3)
				v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			ax_s1 <= PROD_W'(mode_x) * PROD_W'(x_pixel);
			ay_s1 <= PROD_W'(mode_y) * PROD_W'(y_pixel);
		end
		if (en_s2) begin
			ax_s2 <= ax_s1;
			ay_s2 <= ay_s1;
			qx_s2 <= mul_x[PROD_W +: KEEP_W];
			qy_s2 <= mul_y[PROD_W +: KEEP_W];
		end
		if (en_s3) begin
			phx_s3 <= fix_phase(ax_s2, qx_s2, DIV_X_V);
			phy_s3 <= fix_phase(ay_s2, qy_s2, DIV_Y_V);
		end
	end

	assign {out_data.flip_x, out_data.addr_x} = map_quad(phx_s3);
	assign {out_data.flip_y, out_data.addr_y} = map_quad(phy_s3);
endmodule
`default_nettype wire

>>> design/swm_shade.sv
`default_nettype none
module swm_shade (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire swm_pkg::shade_in_t in_data,
	output logic out_valid,
	input wire logic out_ready,
	output logic [swm_pkg::COLOR_W-1:0] red,
	output logic [swm_pkg::COLOR_W-1:0] green,
	output logic [swm_pkg::COLOR_W-1:0] blue
);
	import swm_pkg::*;

	localparam int SQ_W = 2 * COS_W;
	localparam int LVL_W = COLOR_W + Q_W;
	localparam int GAIN_W = Q_W + 4;

	logic v_s5, v_s6, v_s7;
	logic en_s5, en_s6, en_s7;
	logic neg_s5;
	logic [COS_W-1:0] mag_s5;
	logic [COLOR_W-1:0] r_s6, g_s6, b_s6;
	logic [Q_W-1:0] m_s6;
	logic node_s6;
	logic [COLOR_W-1:0] red_s7, green_s7, blue_s7;

	logic [SQ_W-1:0] sq;
	logic neg_x, neg_y, cold;
	logic [LVL_W-1:0] lvl, white;
	logic [COLOR_W-1:0] shade;
	logic [GAIN_W-1:0] gain;

	function automatic logic [COLOR_W-1:0] blend(
		input logic [COLOR_W-1:0] c,
		input logic [Q_W-1:0] m,
		input logic [LVL_W-1:0] wt
	);
		logic [LVL_W-1:0] sum;
		sum = LVL_W'(c) * LVL_W'(m) + wt;
		return sum[FRAC_W +: COLOR_W];
	endfunction

	assign en_s7 = !v_s7 || out_ready;
	assign en_s6 = !v_s6 || en_s7;
	assign en_s5 = !v_s5 || en_s6;
	assign in_ready = en_s5;
	assign out_valid = v_s7;

	// Stage 5: pressure magnitude and sign; a zero cosine carries no sign.
	assign sq = SQ_W'(in_data.cos_x) * SQ_W'(in_data.cos_y);
	assign neg_x = in_data.flip_x && (in_data.cos_x != '0);
	assign neg_y = in_data.flip_y && (in_data.cos_y != '0);

	// Stage 6: diverging colormap level and node weight.
	assign lvl = LVL_W'(ONE_Q15 - Q_W'(mag_s5)) * LVL_W'(CMAX);
	assign shade = lvl[FRAC_W +: COLOR_W];
	assign cold = neg_s5 && (mag_s5 != '0);
	assign gain = GAIN_W'(mag_s5) * GAIN_W'(NODE_GAIN);

	// Stage 7: white share of the blend.
	assign white = LVL_W'(ONE_Q15 - m_s6) * LVL_W'(CMAX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en_s5)
				v_s5 <= in_valid;
			if (en_s6)
				v_s6 <= v_s5;
			if (en_s7)
				v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			mag_s5 <= sq[SQ_W-1:FRAC_W];
			neg_s5 <= neg_x ^ neg_y;
		end
		if (en_s6) begin
			r_s6 <= cold ? shade : CMAX;
			g_s6 <= shade;
			b_s6 <= cold ? CMAX : shade;
			node_s6 <= (mag_s5 <= NODE_LIMIT);
			m_s6 <= gain[Q_W-1:0];
		end
		if (en_s7) begin
			if (node_s6) begin
				red_s7 <= blend(r_s6, m_s6, white);
				green_s7 <= blend(g_s6, m_s6, white);
				blue_s7 <= blend(b_s6, m_s6, white);
			end else begin
				red_s7 <= r_s6;
				green_s7 <= g_s6;
				blue_s7 <= b_s6;
			end
		end
	end

	assign red = red_s7;
	assign green = green_s7;
	assign blue = blue_s7;
endmodule
`default_nettype wire

>>> design/standing_wave_mode_pixel_colormap.sv
// Standing-wave mode pixel colormap.
// pixel: one transaction per pixel coordinate (x_pixel, y_pixel).
// color: one transaction per pixel with its red, green and blue bytes, in
//   the same order as the pixels came in.
// cfg: register writes, index 0 = mode_x, index 1 = mode_y; other indexes
//   are dropped. cfg.ready is always high. Write only while no pixel is
//   in flight.
// Throughput: one pixel per clock while color.ready stays high and the
//   table is loaded. Pipeline: seven register stages (three phase
//   stages, the cosine table read, three shading stages), the first of
//   them loaded on the accepting edge.
// Reset: modes return to 2 and the pipeline empties. The cosine table RAM
//   is then loaded from the package table, one entry per cycle, for all
//   QSTEPS + 1 = 1025 entries; pixel.ready stays low during that load.
// Stall: when color.ready is low the output holds; each stage keeps
//   taking items until the one ahead of it is full, so pixel.ready drops
//   only once all seven stages hold an item.
`default_nettype none
module standing_wave_mode_pixel_colormap (
	input wire logic clk,
	input wire logic arst_n,
	swm_pix_if.sink pixel,
	swm_rgb_if.source color,
	swm_cfg_if.sink cfg
);
	import swm_pkg::*;

	// Configuration registers.
	logic [MODE_W-1:0] mode_x_q, mode_y_q;

	// Table load after reset.
	logic fill_busy_q;
	logic [ADDR_W-1:0] fill_cnt_q;
	logic [COS_W-1:0] fill_data;

	// Phase stages to table read.
	logic ph_in_ready;
	logic ph_valid;
	phase_t ph_data;

	// Table read stage.
	logic v_s4, en_s4;
	logic flip_x_s4, flip_y_s4;
	logic [COS_W-1:0] cos_x_s4, cos_y_s4;

	// Shading stages.
	logic sh_in_ready;
	shade_in_t sh_in;

	// Take every cfg transaction; the index picks the register.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_x_q <= MODE_RESET;
			mode_y_q <= MODE_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_MODE_X: mode_x_q <= cfg.data;
				REG_MODE_Y: mode_y_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Walk the table addresses once after reset, then stop.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_busy_q <= 1'b1;
			fill_cnt_q <= '0;
		end else if (fill_busy_q) begin
			if (fill_cnt_q == ADDR_W'(QSTEPS))
				fill_busy_q <= 1'b0;
			else
				fill_cnt_q <= fill_cnt_q + 1'b1;
		end
	end

	assign fill_data = COS_ROM[fill_cnt_q];

	// Hold off pixel transactions until the table is loaded.
	assign pixel.ready = ph_in_ready && !fill_busy_q;

	swm_phase u_phase (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(pixel.valid && !fill_busy_q),
		.in_ready(ph_in_ready),
		.x_pixel(pixel.x_pixel),
		.y_pixel(pixel.y_pixel),
		.mode_x(mode_x_q),
		.mode_y(mode_y_q),
		.out_valid(ph_valid),
		.out_ready(en_s4),
		.out_data(ph_data)
	);

	// Table read: the RAM output register is this stage's data, so it
	// advances on the same enable as the valid bit.
	assign en_s4 = !v_s4 || sh_in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s4 <= 1'b0;
		else if (en_s4)
			v_s4 <= ph_valid;
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			flip_x_s4 <= ph_data.flip_x;
			flip_y_s4 <= ph_data.flip_y;
		end
	end

	swm_ram #(
		.WIDTH(COS_W),
		.DEPTH(QSTEPS + 1)
	) u_cos_ram (
		.clk(clk),
		.we(fill_busy_q),
		.waddr(fill_cnt_q),
		.wdata(fill_data),
		.re(en_s4),
		.raddr_a(ph_data.addr_x),
		.raddr_b(ph_data.addr_y),
		.rdata_a(cos_x_s4),
		.rdata_b(cos_y_s4)
	);

	assign sh_in.flip_x = flip_x_s4;
	assign sh_in.cos_x = cos_x_s4;
	assign sh_in.flip_y = flip_y_s4;
	assign sh_in.cos_y = cos_y_s4;

	swm_shade u_shade (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(v_s4),
		.in_ready(sh_in_ready),
		.in_data(sh_in),
		.out_valid(color.valid),
		.out_ready(color.ready),
		.red(color.red),
		.green(color.green),
		.blue(color.blue)
	);
endmodule
`default_nettype wire

>>> design/swm_checker.sv
`default_nettype none
`include "standing_wave_mode_pixel_colormap_macros.svh"
module swm_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [swm_pkg::COLOR_W-1:0] red,
	input wire logic [swm_pkg::COLOR_W-1:0] green,
	input wire logic [swm_pkg::COLOR_W-1:0] blue
);
	import swm_pkg::*;

	logic in_acc, out_acc;
	logic [FLIGHT_W-1:0] flight_q;

	assign in_acc = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// Count pixels taken in but not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			flight_q <= '0;
		else if (in_acc && !out_acc)
			flight_q <= flight_q + 1'b1;
		else if (out_acc && !in_acc)
			flight_q <= flight_q - 1'b1;
	end

	`SWM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(red) && $stable(green) && $stable(blue))
	`SWM_ASSERT_IMPL(a_out_has_item, out_valid, flight_q != '0)
	`SWM_ASSERT_IMPL(a_flight_bound, in_acc || out_valid, flight_q <= FLIGHT_W'(PIPE_DEPTH))
	`SWM_ASSERT_RESET(a_load_after_reset, !arst_n, !in_ready)
endmodule

bind standing_wave_mode_pixel_colormap swm_checker u_swm_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(pixel.valid),
	.in_ready(pixel.ready),
	.out_valid(color.valid),
	.out_ready(color.ready),
	.red(color.red),
	.green(color.green),
	.blue(color.blue)
);
`default_nettype wire

>>> sim/swm_colormap_monitor.sv
`timescale 1ns / 100ps
module swm_colormap_monitor (
	input logic clk,
	input logic arst_n,
	swm_pix_if pixel,
	swm_rgb_if color,
	swm_cfg_if cfg,
	output int fail_count,
	output int colors_outstanding
);
	import swm_pkg::*;

	typedef longint unsigned u64_t;

	typedef struct packed {
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} rgb_t;

	localparam u64_t ANGLE_STEP_Q30 = 64'd1686629713;
	localparam u64_t UNITY_Q30 = 64'd1 << 30;
	localparam u64_t UNITY_Q15 = 64'd32768;
	localparam u64_t WHITE_LEVEL = 64'd255;
	localparam u64_t BLEND_LIMIT = 64'd3276;
	localparam u64_t BLEND_GAIN = 64'd10;
	localparam int TAYLOR_TERMS = 9;

	int quarter_cos [0:QSTEPS];
	logic [MODE_W-1:0] mode_x_copy;
	logic [MODE_W-1:0] mode_y_copy;
	rgb_t colors_due [$];
	int mismatches = 0;

	// cos(k*pi/(2Q)) in Q1.15, Taylor series in Q2.30 with every term truncated
	initial begin : build_quarter_cos
		u64_t theta;
		u64_t x2;
		u64_t term;
		u64_t n;
		longint acc;
		int k;
		for (k = 0; k <= QSTEPS; k++) begin
			theta = (u64_t'(k) * ANGLE_STEP_Q30) >> COS_TABLE_BITS;
			x2 = (theta * theta) >> 30;
			term = UNITY_Q30;
			acc = longint'(UNITY_Q30);
			for (n = 1; n <= TAYLOR_TERMS; n++) begin
				term = ((term * x2) >> 30) / ((2 * n - 1) * (2 * n));
				if (n[0])
					acc = acc - longint'(term);
				else
					acc = acc + longint'(term);
			end
			if (acc < 0)
				acc = 0;
			acc = (acc + 16384) >>> 15;
			if (acc > 32767)
				acc = 32767;
			quarter_cos[k] = int'(acc);
		end
	end

	function automatic int cos_at(u64_t phase);
		u64_t turn_pos;
		u64_t quad;
		int r;
		turn_pos = phase % (4 * QSTEPS);
		quad = turn_pos / QSTEPS;
		r = int'(turn_pos % QSTEPS);
		case (quad)
			0: return quarter_cos[r];
			1: return -quarter_cos[QSTEPS - r];
			2: return -quarter_cos[r];
			default: return quarter_cos[QSTEPS - r];
		endcase
	endfunction

	function automatic rgb_t pixel_color(logic [MODE_W-1:0] mx, logic [MODE_W-1:0] my,
			logic [PIX_W-1:0] xp, logic [PIX_W-1:0] yp);
		u64_t ph_x;
		u64_t ph_y;
		int cx;
		int cy;
		bit neg;
		u64_t ax;
		u64_t ay;
		u64_t mag;
		u64_t m;
		u64_t c [3];
		rgb_t res;
		int i;
		ph_x = u64_t'(mx) * u64_t'(xp) * 2 * QSTEPS / (IMG_WIDTH - 1);
		ph_y = u64_t'(my) * u64_t'(yp) * 2 * QSTEPS / (IMG_HEIGHT - 1);
		cx = cos_at(ph_x);
		cy = cos_at(ph_y);
		neg = (cx < 0) != (cy < 0);
		ax = u64_t'(cx < 0 ? -cx : cx);
		ay = u64_t'(cy < 0 ? -cy : cy);
		mag = (ax * ay) >> FRAC_W;
		if (neg && mag != 0) begin
			c[0] = (WHITE_LEVEL * (UNITY_Q15 - mag)) >> FRAC_W;
			c[1] = c[0];
			c[2] = WHITE_LEVEL;
		end else begin
			c[0] = WHITE_LEVEL;
			c[1] = (WHITE_LEVEL * (UNITY_Q15 - mag)) >> FRAC_W;
			c[2] = c[1];
		end
		// near a node, fade toward white
		if (mag <= BLEND_LIMIT) begin
			m = BLEND_GAIN * mag;
			for (i = 0; i < 3; i++)
				c[i] = (c[i] * m + WHITE_LEVEL * (UNITY_Q15 - m)) >> FRAC_W;
		end
		res.red = c[0][COLOR_W-1:0];
		res.green = c[1][COLOR_W-1:0];
		res.blue = c[2][COLOR_W-1:0];
		return res;
	endfunction

	function automatic int field_differs(string name, logic [COLOR_W-1:0] want,
			logic [COLOR_W-1:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track_colors
		rgb_t want;
		if (!arst_n) begin
			mode_x_copy = MODE_RESET;
			mode_y_copy = MODE_RESET;
			colors_due.delete();
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_MODE_X: mode_x_copy = cfg.data;
					REG_MODE_Y: mode_y_copy = cfg.data;
					default: ;
				endcase
			end
			if (pixel.valid && pixel.ready)
				colors_due.push_back(pixel_color(mode_x_copy, mode_y_copy,
					pixel.x_pixel, pixel.y_pixel));
			if (color.valid && color.ready) begin
				if (colors_due.size() == 0) begin
					$error("color transaction with no pixel pending: red %0d green %0d blue %0d",
						color.red, color.green, color.blue);
					mismatches++;
				end else begin
					want = colors_due.pop_front();
					mismatches += field_differs("red", want.red, color.red);
					mismatches += field_differs("green", want.green, color.green);
					mismatches += field_differs("blue", want.blue, color.blue);
				end
			end
		end
		colors_outstanding <= colors_due.size();
		fail_count <= mismatches;
	end

endmodule

>>> sim/tb_standing_wave_mode_pixel_colormap.sv
`timescale 1ns / 100ps
module tb_standing_wave_mode_pixel_colormap;
	import swm_pkg::*;

	localparam int RESET_CYCLES = 11;
	// Reset load of the cosine RAM aside, the rest of the limit covers
	// ~1400 pixels with worst-case sender gaps and receiver stalls, many times over.
	localparam int CYCLE_LIMIT = 200000;
	localparam int LONG_HOLD_CYCLES = 60;
	localparam int FLOOD_PIXELS = 40;
	localparam int PHASES = 8;
	localparam int RANDOM_PER_PHASE = 165;

	typedef enum int {RX_STEADY, RX_COIN, RX_SPARSE_STALL, RX_SLOW} rx_style_e;

	logic clk;
	logic arst_n;

	swm_pix_if pixel();
	swm_rgb_if color();
	swm_cfg_if cfg();

	int color_errors;
	int colors_in_flight;

	// Sender state: remaining items in the current burst, and a flag that
	// suppresses gaps while we deliberately flood the input.
	int burst_left;
	bit flood;
	// Bumped by the stimulus to ask the receiver for one long hold-off.
	int hold_requests;

	standing_wave_mode_pixel_colormap uut (
		.clk(clk),
		.arst_n(arst_n),
		.pixel(pixel),
		.color(color),
		.cfg(cfg)
	);

	swm_colormap_monitor u_monitor (
		.clk(clk),
		.arst_n(arst_n),
		.pixel(pixel),
		.color(color),
		.cfg(cfg),
		.fail_count(color_errors),
		.colors_outstanding(colors_in_flight)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Mostly uniform coordinates, with a share pinned to the image borders.
	function automatic logic [PIX_W-1:0] pick_coord();
		case ($urandom_range(0, 9))
			0: return PIX_W'($urandom_range(0, 3));
			1: return PIX_W'((1 << PIX_W) - 1 - $urandom_range(0, 3));
			default: return PIX_W'($urandom);
		endcase
	endfunction

	// Offer one pixel and hold it until the transaction completes. Keep
	// valid high inside a burst; drop it for a random gap between bursts.
	task automatic offer_pixel(input logic [PIX_W-1:0] xp, input logic [PIX_W-1:0] yp);
		int gap;
		pixel.valid <= 1'b1;
		pixel.x_pixel <= xp;
		pixel.y_pixel <= yp;
		do @(posedge clk); while (!pixel.ready);
		if (burst_left > 0)
			burst_left--;
		if (!flood && burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			// one burst in four runs straight into the next with no gap
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				pixel.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Stop offering and wait until every predicted color has come out.
	task automatic drain_colors();
		pixel.valid <= 1'b0;
		do @(posedge clk); while (colors_in_flight != 0);
	endtask

	// One register write; the caller lowers valid after its last write so
	// valid is never dropped and raised in the same step.
	task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [MODE_W-1:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		do @(posedge clk); while (!cfg.ready);
	endtask

	// Program both modes, then hit an unmapped index that must be dropped.
	// Call only with the pipeline empty.
	task automatic program_modes(input logic [MODE_W-1:0] mx, input logic [MODE_W-1:0] my);
		cfg_write(REG_MODE_X, mx);
		cfg_write(REG_MODE_Y, my);
		cfg_write(CFG_INDEX_W'($urandom_range(int'(REG_MODE_Y) + 1, (1 << CFG_INDEX_W) - 1)),
			MODE_W'($urandom));
		cfg.valid <= 1'b0;
	endtask

	// Receiver: ready follows a style picked at random for runs of random
	// length, including fully open stretches. On request, hold ready low for
	// a long count so the pipeline fills and backs up into the pixel input.
	initial begin : color_receiver
		rx_style_e style;
		int run_left;
		int hold_done;
		style = RX_STEADY;
		run_left = 0;
		hold_done = 0;
		color.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_requests != hold_done) begin
				hold_done = hold_requests;
				color.ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
			end
			if (run_left == 0) begin
				style = rx_style_e'($urandom_range(RX_STEADY, RX_SLOW));
				run_left = $urandom_range(20, 200);
			end
			run_left--;
			case (style)
				RX_STEADY: color.ready <= 1'b1;
				RX_COIN: color.ready <= 1'($urandom_range(0, 1));
				RX_SPARSE_STALL: color.ready <= ($urandom_range(0, 7) != 0);
				RX_SLOW: color.ready <= ($urandom_range(0, 3) == 0);
				default: color.ready <= 1'b1;
			endcase
		end
	end

	// Abort a hung run.
	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("== FAIL ==");
		$finish;
	end

	initial begin : stimulus
		int phase;
		int k;
		flood = 1'b0;
		burst_left = 0;
		hold_requests = 0;
		arst_n <= 1'b0;
		pixel.valid <= 1'b0;
		pixel.x_pixel <= '0;
		pixel.y_pixel <= '0;
		cfg.valid <= 1'b0;
		cfg.index <= REG_MODE_X;
		cfg.data <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Directed pixels at the reset modes (two half-waves per axis):
		// the four corners, antinodes of both signs, and the nodal lines
		// where the color fades toward white.
		offer_pixel('0, '0);
		offer_pixel('1, '1);
		offer_pixel('0, '1);
		offer_pixel('1, '0);
		offer_pixel(9'd255, 9'd0);
		offer_pixel(9'd255, 9'd255);
		offer_pixel(9'd127, 9'd0);
		offer_pixel(9'd128, 9'd0);
		offer_pixel(9'd383, 9'd0);
		offer_pixel(9'd384, 9'd0);
		offer_pixel(9'd127, 9'd127);
		offer_pixel(9'd0, 9'd127);
		offer_pixel(9'd0, 9'd128);
		offer_pixel(9'd255, 9'd127);
		offer_pixel(9'd1, 9'd510);
		offer_pixel(9'd170, 9'd341);

		// Long receiver hold-off while the sender keeps offering without
		// gaps: the stages fill up and pixel.ready has to drop.
		hold_requests++;
		flood = 1'b1;
		for (k = 0; k < FLOOD_PIXELS; k++)
			offer_pixel(pick_coord(), pick_coord());
		flood = 1'b0;

		for (phase = 0; phase < PHASES; phase++) begin
			if (phase > 0) begin
				// registers change only with nothing in flight
				drain_colors();
				case (phase)
					1: program_modes(4'd0, 4'd0);
					2: program_modes(4'd15, 4'd15);
					3: program_modes(4'd0, 4'd15);
					4: program_modes(4'd15, 4'd0);
					5: program_modes(4'd1, 4'd3);
					default: program_modes(MODE_W'($urandom), MODE_W'($urandom));
				endcase
				// with mode zero on both axes the pressure is flat at full scale
				if (phase == 1) begin
					offer_pixel('0, '0);
					offer_pixel('1, '1);
					offer_pixel(9'd255, 9'd100);
				end
			end
			for (k = 0; k < RANDOM_PER_PHASE; k++) begin
				offer_pixel(pick_coord(), pick_coord());
				// now and then let the whole pipeline run dry mid-phase
				if ($urandom_range(0, 99) == 0)
					drain_colors();
			end
		end

		drain_colors();
		// leave room for any stray color transaction to show up
		repeat (PIPE_DEPTH + 4) @(posedge clk);
		if (color_errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+design
design/swm_pkg.sv
design/swm_pix_if.sv
design/swm_rgb_if.sv
design/swm_cfg_if.sv
design/swm_ram.sv
design/swm_phase.sv
design/swm_shade.sv
design/standing_wave_mode_pixel_colormap.sv
design/swm_checker.sv
sim/swm_colormap_monitor.sv
sim/tb_standing_wave_mode_pixel_colormap.sv
